@@ sv/sdd_pkg.sv @@
`timescale 1ns / 1ps

package sdd_pkg;

    typedef enum logic [1:0] {
        CMD_RAW     = 2'd0,
        CMD_GLYPH   = 2'd1,
        CMD_NUMBER  = 2'd2,
        CMD_REFRESH = 2'd3
    } t_command;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PUT  = 5'b00010,
        S_DIV  = 5'b00100,
        S_LOAD = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    typedef logic [7:0][3:0] t_digits;

    localparam logic [7:0] BYTE_DATA_CMD = 8'h40;
    localparam logic [7:0] BYTE_ADDR_CMD = 8'hC0;
    localparam logic [7:0] BYTE_DISP_CMD = 8'h8F;
    localparam logic [7:0] BYTE_PAD      = 8'h00;

    localparam logic [4:0] GLYPH_MAX    = 5'd18;
    localparam logic [4:0] FRAME_FIRST  = 5'd0;
    localparam logic [4:0] FRAME_ADDR   = 5'd1;
    localparam logic [4:0] FRAME_LASTPD = 5'd17;
    localparam logic [4:0] FRAME_LAST   = 5'd18;
    localparam logic [4:0] PUT_LAST     = 5'd8;
    localparam logic [4:0] LOAD_LAST    = 5'd7;

    localparam logic [15:0] RECIP_TEN = 16'hCCCD;

    function automatic logic [7:0] font_lookup(input logic [4:0] idx);
        logic [7:0] seg;
        seg = 8'h00;
        unique case (idx)
            5'd0:    seg = 8'h3F;
            5'd1:    seg = 8'h06;
            5'd2:    seg = 8'h5B;
            5'd3:    seg = 8'h4F;
            5'd4:    seg = 8'h66;
            5'd5:    seg = 8'h6D;
            5'd6:    seg = 8'h7D;
            5'd7:    seg = 8'h07;
            5'd8:    seg = 8'h7F;
            5'd9:    seg = 8'h6F;
            5'd10:   seg = 8'h40;
            5'd11:   seg = 8'h80;
            5'd12:   seg = 8'h7B;
            5'd13:   seg = 8'h39;
            5'd14:   seg = 8'h79;
            5'd15:   seg = 8'h71;
            5'd16:   seg = 8'h76;
            5'd17:   seg = 8'h38;
            5'd18:   seg = 8'h3E;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

@@ sv/sdd_digits.sv @@
`timescale 1ns / 1ps

module sdd_digits (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  logic [15:0]     i_number,
    output logic            o_done,
    output sdd_pkg::t_digits o_digits
);

    logic [15:0]      r_num;
    logic [2:0]       r_cnt;
    logic             r_busy;
    sdd_pkg::t_digits r_digits;
    logic [31:0]      w_prod;
    logic [15:0]      w_quot;
    logic [15:0]      w_rem;

    // divide by ten through the reciprocal, exact for 16-bit values
    assign w_prod = r_num * sdd_pkg::RECIP_TEN;
    assign w_quot = {3'b000, w_prod[31:19]};
    assign w_rem  = r_num - (w_quot << 3) - (w_quot << 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_cnt  <= 3'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_num <= i_number;
        end else if (r_busy) begin
            r_num           <= w_quot;
            r_digits[r_cnt] <= w_rem[3:0];
        end
    end

    assign o_done   = r_busy && (r_cnt == 3'd7);
    assign o_digits = r_digits;

endmodule

@@ sv/seven_segment_display_buffer_driver.sv @@
`timescale 1ns / 1ps
// A refresh item streams 19 bytes, one per cycle; after accept, the state register and then
// the output registers lie before the first byte. A raw or glyph write is a read-modify-write
// sweep over 8 memory lines; a number load is 8 divide-by-ten steps, then 8 line writes.
// A new command is taken only in idle; an ignored write stays idle. No receiver stall.
// Reset (synchronous, active low) returns to idle and marks all lines as blank.
module seven_segment_display_buffer_driver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_command,
    input  logic [3:0]  i_position,
    input  logic [7:0]  i_segments,
    input  logic [4:0]  i_glyph,
    input  logic [15:0] i_number,
    output logic        o_busy,
    output logic        o_strobe,
    output logic [7:0]  o_out_byte,
    output logic        o_end_of_transfer,
    output logic        o_last
);

    sdd_pkg::t_state  r_state;
    sdd_pkg::t_state  n_state;
    logic [4:0]       r_cnt;
    logic [4:0]       n_cnt;
    logic [7:0]       r_pattern;
    logic [7:0]       r_mask;
    logic [7:0]       r_mem [0:7];
    logic [7:0]       r_valid;
    logic [7:0]       r_rdata;
    logic             r_rvalid;

    logic             w_accept;
    logic             w_put_ok;
    logic [7:0]       w_put_pattern;
    logic             w_load;
    logic             w_done;
    sdd_pkg::t_digits w_digits;
    logic [2:0]       w_raddr;
    logic             w_we;
    logic [2:0]       w_waddr;
    logic [7:0]       w_wdata;
    logic [7:0]       w_seg;
    logic [7:0]       w_old;
    logic [7:0]       w_byte;
    logic             w_eot;

    assign o_busy   = (r_state != sdd_pkg::S_IDLE);
    assign w_accept = i_start && (r_state == sdd_pkg::S_IDLE);
    assign w_load   = w_accept && (i_command == sdd_pkg::CMD_NUMBER);

    sdd_digits u_digits (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_number (i_number),
        .o_done   (w_done),
        .o_digits (w_digits)
    );

    always_comb begin
        w_put_ok      = 1'b0;
        w_put_pattern = i_segments;
        case (i_command)
            sdd_pkg::CMD_RAW: begin
                w_put_ok = !i_position[3];
            end
            sdd_pkg::CMD_GLYPH: begin
                w_put_ok      = !i_position[3] && (i_glyph <= sdd_pkg::GLYPH_MAX);
                w_put_pattern = sdd_pkg::font_lookup(i_glyph);
            end
            default: begin
                w_put_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + 5'd1;
        unique case (r_state)
            sdd_pkg::S_IDLE: begin
                n_cnt = 5'd0;
                if (w_accept) begin
                    case (i_command) inside
                        sdd_pkg::CMD_RAW, sdd_pkg::CMD_GLYPH: begin
                            if (w_put_ok) n_state = sdd_pkg::S_PUT;
                        end
                        sdd_pkg::CMD_NUMBER:  n_state = sdd_pkg::S_DIV;
                        default:              n_state = sdd_pkg::S_EMIT;
                    endcase
                end
            end
            sdd_pkg::S_PUT: begin
                if (r_cnt == sdd_pkg::PUT_LAST) n_state = sdd_pkg::S_IDLE;
            end
            sdd_pkg::S_DIV: begin
                n_cnt = 5'd0;
                if (w_done) n_state = sdd_pkg::S_LOAD;
            end
            sdd_pkg::S_LOAD: begin
                if (r_cnt == sdd_pkg::LOAD_LAST) n_state = sdd_pkg::S_IDLE;
            end
            sdd_pkg::S_EMIT: begin
                if (r_cnt == sdd_pkg::FRAME_LAST) n_state = sdd_pkg::S_IDLE;
            end
            default: begin
                n_state = sdd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdd_pkg::S_IDLE;
            r_cnt   <= 5'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // digit d sits at bit {d[2], ~d[1:0]} of every line
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pattern <= w_put_pattern;
            r_mask    <= 8'd1 << {i_position[2], ~i_position[1:0]};
        end
    end

    assign w_raddr = (r_state == sdd_pkg::S_EMIT) ? r_cnt[3:1] : r_cnt[2:0];
    assign w_old   = r_rvalid ? r_rdata : 8'h00;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt[2:0];
        w_wdata = 8'h00;
        w_seg   = 8'h00;
        if (r_state == sdd_pkg::S_PUT) begin
            w_waddr = 3'(r_cnt - 5'd1);
            w_we    = (r_cnt != 5'd0);
            w_wdata = r_pattern[w_waddr] ? (w_old | r_mask) : (w_old & ~r_mask);
        end else if (r_state == sdd_pkg::S_LOAD) begin
            w_we = 1'b1;
            for (int b = 0; b < 8; b++) begin
                w_seg      = sdd_pkg::font_lookup({1'b0, w_digits[3'(b) ^ 3'd3]});
                w_wdata[b] = w_seg[r_cnt[2:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata  <= r_mem[w_raddr];
        r_rvalid <= r_valid[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 8'h00;
        end else if (w_we) begin
            r_valid[w_waddr] <= 1'b1;
        end
    end

    always_comb begin
        w_byte = sdd_pkg::BYTE_PAD;
        w_eot  = (r_cnt == sdd_pkg::FRAME_FIRST) || (r_cnt == sdd_pkg::FRAME_LASTPD) ||
                 (r_cnt == sdd_pkg::FRAME_LAST);
        if (r_cnt == sdd_pkg::FRAME_FIRST) begin
            w_byte = sdd_pkg::BYTE_DATA_CMD;
        end else if (r_cnt == sdd_pkg::FRAME_ADDR) begin
            w_byte = sdd_pkg::BYTE_ADDR_CMD;
        end else if (r_cnt == sdd_pkg::FRAME_LAST) begin
            w_byte = sdd_pkg::BYTE_DISP_CMD;
        end else if (!r_cnt[0]) begin
            w_byte = w_old;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= (r_state == sdd_pkg::S_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        o_out_byte        <= w_byte;
        o_end_of_transfer <= w_eot;
        o_last            <= (r_cnt == sdd_pkg::FRAME_LAST);
    end

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> o_end_of_transfer)
        else $error("last byte without end of transfer");

    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sdd_pkg::S_EMIT) && (r_cnt != sdd_pkg::FRAME_LAST)
        |=> (r_state == sdd_pkg::S_EMIT) && o_strobe && !o_last)
        else $error("refresh frame cut short");

    a_no_write_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sdd_pkg::S_EMIT) || (r_state == sdd_pkg::S_IDLE) |-> !w_we)
        else $error("line memory written outside an update");

    a_frame_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sdd_pkg::S_EMIT) && (r_cnt == sdd_pkg::FRAME_LAST)
        |=> o_strobe && o_last && !o_busy)
        else $error("refresh frame did not close");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        sdd_pkg::t_command cmd;
        logic [3:0]  position;
        logic [7:0]  segments;
        logic [4:0]  glyph;
        logic [15:0] number;
        int unsigned gap;
        bit          idle_gap;
        bit          drain_first;
    } t_item;

    typedef struct {
        logic [7:0] data;
        logic       eot;
        logic       fin;
    } t_frame_byte;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 300;

    localparam logic [18:0][7:0] FONT = {
        8'h3E, 8'h38, 8'h76, 8'h71, 8'h79, 8'h39, 8'h7B, 8'h80, 8'h40, 8'h6F,
        8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [1:0]  i_command = '0;
    logic [3:0]  i_position = '0;
    logic [7:0]  i_segments = '0;
    logic [4:0]  i_glyph = '0;
    logic [15:0] i_number = '0;
    logic        o_busy;
    logic        o_strobe;
    logic [7:0]  o_out_byte;
    logic        o_end_of_transfer;
    logic        o_last;

    logic [7:0]  seg_lines [8] = '{default: 8'h00};
    t_frame_byte frame_bytes_q [$];
    t_item       pending_q [$];
    t_item       cur_item;
    int unsigned bytes_due = 0;
    int unsigned bytes_seen = 0;
    int unsigned gap_cnt = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    bit          quiet = 1'b0;

    seven_segment_display_buffer_driver i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .i_command         (i_command),
        .i_position        (i_position),
        .i_segments        (i_segments),
        .i_glyph           (i_glyph),
        .i_number          (i_number),
        .o_busy            (o_busy),
        .o_strobe          (o_strobe),
        .o_out_byte        (o_out_byte),
        .o_end_of_transfer (o_end_of_transfer),
        .o_last            (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("MISMATCH at %0t ns: %s got 0x%0h, expected 0x%0h (byte %0d)",
                 $time, what, got, want, bytes_seen);
    endtask

    function automatic void put_pattern(input logic [3:0] pos, input logic [7:0] pattern);
        logic [2:0] bit_idx;
        int s;
        if (pos > 4'd7) return;
        bit_idx = (pos < 4'd4) ? 3'(4'd3 - pos) : 3'(4'd11 - pos);
        for (s = 0; s < 8; s++) begin
            seg_lines[s][bit_idx] = pattern[s];
        end
    endfunction

    function automatic void queue_byte(input logic [7:0] data, input logic eot,
                                       input logic fin);
        t_frame_byte fb;
        fb.data = data;
        fb.eot  = eot;
        fb.fin  = fin;
        frame_bytes_q.push_back(fb);
        bytes_due++;
    endfunction

    function automatic void apply_command(input t_item it);
        logic [15:0] rest;
        int d;
        int s;
        case (it.cmd)
            sdd_pkg::CMD_RAW: put_pattern(it.position, it.segments);
            sdd_pkg::CMD_GLYPH: begin
                if (it.glyph <= sdd_pkg::GLYPH_MAX) put_pattern(it.position, FONT[it.glyph]);
            end
            sdd_pkg::CMD_NUMBER: begin
                rest = it.number;
                for (d = 0; d < 8; d++) begin
                    put_pattern(4'(d), FONT[rest % 16'd10]);
                    rest = rest / 16'd10;
                end
            end
            sdd_pkg::CMD_REFRESH: begin
                queue_byte(sdd_pkg::BYTE_DATA_CMD, 1'b1, 1'b0);
                queue_byte(sdd_pkg::BYTE_ADDR_CMD, 1'b0, 1'b0);
                for (s = 0; s < 8; s++) begin
                    queue_byte(seg_lines[s], 1'b0, 1'b0);
                    queue_byte(sdd_pkg::BYTE_PAD, s == 7, 1'b0);
                end
                queue_byte(sdd_pkg::BYTE_DISP_CMD, 1'b1, 1'b1);
            end
        endcase
    endfunction

    task automatic add_item(input sdd_pkg::t_command cmd, input logic [3:0] pos,
                            input logic [7:0] seg, input logic [4:0] gl,
                            input logic [15:0] num, input bit drain);
        t_item it;
        it.cmd         = cmd;
        it.position    = pos;
        it.segments    = seg;
        it.glyph       = gl;
        it.number      = num;
        it.gap         = quiet ? 0 : $urandom_range(0, 8);
        it.idle_gap    = 1'($urandom_range(0, 1));
        it.drain_first = drain;
        pending_q.push_back(it);
    endtask

    // driver: hold the item while busy, then wait out the drawn gap
    always @(posedge i_clk) begin
        logic fire;
        logic hold;
        logic go;
        fire = i_start && !o_busy;
        hold = i_start && !fire;
        go   = 1'b0;
        if (fire) begin
            apply_command(cur_item);
            gap_cnt = 0;
        end
        if (i_rst_n && !hold && pending_q.size() > 0) begin
            if (gap_cnt >= pending_q[0].gap &&
                (!pending_q[0].drain_first || bytes_seen >= bytes_due)) begin
                go = 1'b1;
            end else if (!pending_q[0].idle_gap || !o_busy) begin
                gap_cnt++;
            end
        end
        if (go) begin
            cur_item = pending_q.pop_front();
            i_start    <= 1'b1;
            i_command  <= cur_item.cmd;
            i_position <= cur_item.position;
            i_segments <= cur_item.segments;
            i_glyph    <= cur_item.glyph;
            i_number   <= cur_item.number;
        end else if (!hold) begin
            i_start    <= 1'b0;
            i_command  <= 2'($urandom);
            i_position <= 4'($urandom);
            i_segments <= 8'($urandom);
            i_glyph    <= 5'($urandom);
            i_number   <= 16'($urandom);
        end
    end

    always @(posedge i_clk) begin
        t_frame_byte want;
        if (i_rst_n && o_strobe) begin
            bytes_seen <= bytes_seen + 1;
            if (frame_bytes_q.size() == 0) begin
                report_mismatch("unexpected byte", o_out_byte, 0);
            end else begin
                want = frame_bytes_q.pop_front();
                if (o_out_byte !== want.data)
                    report_mismatch("out_byte", o_out_byte, want.data);
                if (o_end_of_transfer !== want.eot)
                    report_mismatch("end_of_transfer", o_end_of_transfer, want.eot);
                if (o_last !== want.fin)
                    report_mismatch("last", o_last, want.fin);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int n;
        sdd_pkg::t_command cmd;
        logic [3:0] pos;
        logic [4:0] gl;

        add_item(sdd_pkg::CMD_REFRESH, 4'($urandom), 8'($urandom), 5'($urandom),
                 16'($urandom), 1'b0);
        add_item(sdd_pkg::CMD_RAW, 4'd0, 8'hFF, 5'($urandom), 16'($urandom), 1'b0);
        add_item(sdd_pkg::CMD_RAW, 4'd3, 8'h55, 5'($urandom), 16'($urandom), 1'b0);
        add_item(sdd_pkg::CMD_RAW, 4'd4, 8'hAA, 5'($urandom), 16'($urandom), 1'b0);
        add_item(sdd_pkg::CMD_RAW, 4'd7, 8'h80, 5'($urandom), 16'($urandom), 1'b0);
        add_item(sdd_pkg::CMD_RAW, 4'd8, 8'hFF, 5'($urandom), 16'($urandom), 1'b0);
        add_item(sdd_pkg::CMD_RAW, 4'd15, 8'h01, 5'($urandom), 16'($urandom), 1'b0);
        add_item(sdd_pkg::CMD_REFRESH, 4'($urandom), 8'($urandom), 5'($urandom),
                 16'($urandom), 1'b0);
        add_item(sdd_pkg::CMD_GLYPH, 4'd1, 8'($urandom), 5'd0, 16'($urandom), 1'b0);
        add_item(sdd_pkg::CMD_GLYPH, 4'd6, 8'($urandom), 5'd18, 16'($urandom), 1'b0);
        add_item(sdd_pkg::CMD_GLYPH, 4'd2, 8'($urandom), 5'd19, 16'($urandom), 1'b0);
        add_item(sdd_pkg::CMD_GLYPH, 4'd5, 8'($urandom), 5'd31, 16'($urandom), 1'b0);
        add_item(sdd_pkg::CMD_GLYPH, 4'd9, 8'($urandom), 5'd8, 16'($urandom), 1'b0);
        add_item(sdd_pkg::CMD_REFRESH, 4'($urandom), 8'($urandom), 5'($urandom),
                 16'($urandom), 1'b0);
        add_item(sdd_pkg::CMD_NUMBER, 4'($urandom), 8'($urandom), 5'($urandom),
                 16'd0, 1'b0);
        add_item(sdd_pkg::CMD_REFRESH, 4'($urandom), 8'($urandom), 5'($urandom),
                 16'($urandom), 1'b0);
        add_item(sdd_pkg::CMD_NUMBER, 4'($urandom), 8'($urandom), 5'($urandom),
                 16'hFFFF, 1'b0);
        add_item(sdd_pkg::CMD_REFRESH, 4'($urandom), 8'($urandom), 5'($urandom),
                 16'($urandom), 1'b0);
        add_item(sdd_pkg::CMD_NUMBER, 4'($urandom), 8'($urandom), 5'($urandom),
                 16'd12345, 1'b1);
        add_item(sdd_pkg::CMD_RAW, 4'd0, 8'h00, 5'($urandom), 16'($urandom), 1'b0);
        add_item(sdd_pkg::CMD_GLYPH, 4'd7, 8'($urandom), 5'd11, 16'($urandom), 1'b0);
        add_item(sdd_pkg::CMD_GLYPH, 4'd3, 8'($urandom), 5'd10, 16'($urandom), 1'b0);
        add_item(sdd_pkg::CMD_REFRESH, 4'($urandom), 8'($urandom), 5'($urandom),
                 16'($urandom), 1'b0);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 20 == 0) quiet = ($urandom_range(0, 3) == 0);
            cmd = sdd_pkg::t_command'($urandom_range(0, 3));
            pos = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(8, 15))
                                              : 4'($urandom_range(0, 7));
            gl  = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(19, 31))
                                              : 5'($urandom_range(0, 18));
            add_item(cmd, pos, 8'($urandom), gl, 16'($urandom),
                     $urandom_range(0, 39) == 0);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() > 0 || i_start || bytes_seen < bytes_due) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (frame_bytes_q.size() > 0)
            report_mismatch("bytes never seen", frame_bytes_q.size(), 0);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
